// ===== rtl/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants of the piecewise linear interpolator
// Widths, status and request codes, and the command/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int DATA_W    = 32;               // Q16.16 sample width
  localparam int POINTS    = 256;              // breakpoint slots
  localparam int IDX_W     = $clog2(POINTS);   // slot index width
  localparam int CNT_W     = IDX_W + 1;        // point_count width
  localparam int STAT_W    = 3;
  localparam int PROD_W    = 2 * DATA_W;       // exact |dx|*|dy|
  localparam int QUOT_W    = 36;               // quotient bits kept before saturation
  localparam int DIV_STEPS = QUOT_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
  localparam int SUM_W     = QUOT_W + 2;

  // request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_INTERP = 3'd0;
  localparam logic [STAT_W-1:0] STAT_BELOW  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ABOVE  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_SMALL  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ZERO_W = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CAP_LO,
    OP_CHECK,
    OP_MID,
    OP_STEP,
    OP_DIFF,
    OP_MUL,
    OP_OVF,
    OP_DIV,
    OP_ADD,
    OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_LAST,
    RD_MID
  } rd_sel_t;

  typedef struct packed {
    op_t     op;
    rd_sel_t rd_sel;
    logic    ram_we;
    logic    cfg_we;
  } cmd_t;

  typedef struct packed {
    logic few_points;  // fewer than two points in use
    logic below;       // query under the first breakpoint
    logic above;       // query over the last breakpoint
    logic search_end;  // bracketing pair found this step
    logic seg_done;    // result settled without division
    logic ovf;         // quotient too large, saturate
    logic div_last;    // final quotient bit this cycle
  } sts_t;

endpackage

// ===== rtl/pli_channels.sv =====
// ----------------------------------------------------------------------------
// pli_channels: valid/ready channels of the piecewise linear interpolator
// Request, result and configuration channels, each with source and sink views.
// ----------------------------------------------------------------------------
interface pli_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [pli_pkg::IDX_W-1:0]           entry_index;
  logic signed [pli_pkg::DATA_W-1:0]   x_value;
  logic signed [pli_pkg::DATA_W-1:0]   y_value;

  modport source (output valid, kind, entry_index, x_value, y_value, input ready);
  modport sink   (input valid, kind, entry_index, x_value, y_value, output ready);
endinterface

interface pli_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pli_pkg::DATA_W-1:0]   result_value;
  logic [pli_pkg::STAT_W-1:0]          status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

interface pli_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pli_pkg::CNT_W-1:0]           point_count;

  modport source (output valid, point_count, input ready);
  modport sink   (input valid, point_count, output ready);
endinterface

// ===== rtl/piecewise_linear_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top: table-driven piecewise linear function
// Holds up to 256 sorted (x, y) breakpoints in Q16.16 and evaluates queries.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : requests. kind load writes x_value/y_value to slot entry_index
//              and gives no result; kind query evaluates the function at x_value.
//   out_chan : one result per query, result_value plus status
//              (interpolated, below, above, table too small, zero-width segment).
//   cfg_chan : point_count, the number of breakpoints in use; always ready,
//              write it only while no query is in flight.
// Timing: a load is written as it is accepted and the next request may follow at once.
//   A query goes straight to its result when the table is too small or when
//   clamped; an interpolated query runs a binary search, each step on the
//   single read port of the breakpoint memory, then one multiply, then a
//   36-step restoring divider, one quotient bit a cycle.
// Reset: synchronous, rst_n low clears point_count and the controller; the
//   breakpoint table keeps its contents and is undefined until loaded.
// Stall: a result waits in the output register while out_chan.ready is low;
//   the next request is accepted meanwhile, and its result waits for the slot.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_top (
  input  logic       clk,
  input  logic       rst_n,
  pli_in_if.sink     in_chan,
  pli_out_if.source  out_chan,
  pli_cfg_if.sink    cfg_chan
);

  pli_pkg::cmd_t cmd;
  pli_pkg::sts_t sts;
  logic          out_valid_r;

  pli_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_kind     (in_chan.kind),
    .in_ready    (in_chan.ready),
    .out_valid_r (out_valid_r),
    .out_ready   (out_chan.ready),
    .cfg_valid   (cfg_chan.valid),
    .cfg_ready   (cfg_chan.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  pli_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .entry_index (in_chan.entry_index),
    .x_value     (in_chan.x_value),
    .y_value     (in_chan.y_value),
    .cfg_count   (cfg_chan.point_count),
    .out_res_r   (out_chan.result_value),
    .out_stat_r  (out_chan.status)
  );

  assign out_chan.valid = out_valid_r;

`ifndef SYNTHESIS
  a_query_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.kind == pli_pkg::KIND_QUERY))
      |=> !in_chan.ready)
    else $error("request accepted while a query is in progress");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.kind == pli_pkg::KIND_LOAD)
      && !out_chan.valid) |=> !out_chan.valid)
    else $error("load request produced a result");

  a_small_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == pli_pkg::STAT_SMALL))
      |-> (out_chan.result_value == '0))
    else $error("table-too-small result is not zero");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> ((out_chan.status == pli_pkg::STAT_INTERP) ||
                        (out_chan.status == pli_pkg::STAT_BELOW)  ||
                        (out_chan.status == pli_pkg::STAT_ABOVE)  ||
                        (out_chan.status == pli_pkg::STAT_SMALL)  ||
                        (out_chan.status == pli_pkg::STAT_ZERO_W)))
    else $error("result carries an undefined status code");
`endif

endmodule

// ===== rtl/pli_ram.sv =====
// ----------------------------------------------------------------------------
// pli_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/pli_dpath.sv =====
// ----------------------------------------------------------------------------
// pli_dpath: datapath of the piecewise linear interpolator
// Breakpoint memory, search registers, multiplier, serial divider and the
// saturating add, all stepped by the controller's command.
// ----------------------------------------------------------------------------
module pli_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pli_pkg::cmd_t                      cmd,
  output pli_pkg::sts_t                      sts,
  input  logic [pli_pkg::IDX_W-1:0]          entry_index,
  input  logic signed [pli_pkg::DATA_W-1:0]  x_value,
  input  logic signed [pli_pkg::DATA_W-1:0]  y_value,
  input  logic [pli_pkg::CNT_W-1:0]          cfg_count,
  output logic signed [pli_pkg::DATA_W-1:0]  out_res_r,
  output logic [pli_pkg::STAT_W-1:0]         out_stat_r
);

  localparam int DW = pli_pkg::DATA_W;
  localparam int IW = pli_pkg::IDX_W;

  logic [pli_pkg::CNT_W-1:0]   point_count_r;
  logic [pli_pkg::CNT_W-1:0]   n_used;
  logic [IW-1:0]               last_idx;

  logic signed [DW-1:0]        q_r;
  logic [IW-1:0]               lo_r, hi_r, mid_r, mid_w;
  logic signed [DW-1:0]        xlo_r, ylo_r, xhi_r, yhi_r;

  logic [IW-1:0]               rd_addr;
  logic [2*DW-1:0]             rd_data;
  logic signed [DW-1:0]        rd_x, rd_y;

  logic                        go_hi;
  logic [IW-1:0]               new_lo, new_hi;

  logic signed [DW:0]          dx_w, dy_w, dw_w;
  logic [DW-1:0]               mdx_r, mdy_r, mdw_r;
  logic                        neg_r;
  logic [pli_pkg::PROD_W-1:0]  prod_r;
  logic [DW-1:0]               prod_hi;
  logic [DW-1:0]               rem_r;
  logic [pli_pkg::QUOT_W-1:0]  shq_r;
  logic [pli_pkg::DCNT_W-1:0]  cnt_r;
  logic [DW:0]                 trial, trial_sub;
  logic                        trial_ge;

  logic signed [pli_pkg::SUM_W-1:0] sum_w;
  logic signed [DW-1:0]        sat_w;
  logic signed [DW-1:0]        res_r;
  logic [pli_pkg::STAT_W-1:0]  stat_r;

  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  // breakpoint table, x in the upper half of each word
  pli_ram #(.WIDTH(2*DW), .DEPTH(pli_pkg::POINTS)) u_bp_ram (
    .clk     (clk),
    .wr_en   (cmd.ram_we),
    .wr_addr (entry_index),
    .wr_data ({x_value, y_value}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_x = $signed(rd_data[2*DW-1:DW]);
  assign rd_y = $signed(rd_data[DW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else if (cmd.cfg_we) begin
      point_count_r <= cfg_count;
    end
  end

  always_comb begin
    n_used   = (point_count_r > pli_pkg::CNT_W'(pli_pkg::POINTS)) ?
               pli_pkg::CNT_W'(pli_pkg::POINTS) : point_count_r;
    last_idx = IW'(n_used - pli_pkg::CNT_W'(1));
    mid_w    = lo_r + ((hi_r - lo_r) >> 1);
    unique case (cmd.rd_sel)
      pli_pkg::RD_ZERO: rd_addr = '0;
      pli_pkg::RD_LAST: rd_addr = last_idx;
      pli_pkg::RD_MID:  rd_addr = mid_w;
      default:          rd_addr = '0;
    endcase
  end

  // search step: move one end of the bracket onto the midpoint
  always_comb begin
    go_hi  = (q_r <= rd_x);
    new_lo = go_hi ? lo_r : mid_r;
    new_hi = go_hi ? mid_r : hi_r;
  end

  always_comb begin
    dx_w = {q_r[DW-1], q_r} - {xlo_r[DW-1], xlo_r};
    dy_w = {yhi_r[DW-1], yhi_r} - {ylo_r[DW-1], ylo_r};
    dw_w = {xhi_r[DW-1], xhi_r} - {xlo_r[DW-1], xlo_r};
  end

  always_comb begin
    prod_hi   = DW'(prod_r[pli_pkg::PROD_W-1:pli_pkg::QUOT_W]);
    trial     = {rem_r, shq_r[pli_pkg::QUOT_W-1]};
    trial_ge  = (trial >= {1'b0, mdw_r});
    trial_sub = trial - {1'b0, mdw_r};
  end

  always_comb begin
    if (neg_r) begin
      sum_w = pli_pkg::SUM_W'(ylo_r) - $signed({2'b00, shq_r});
    end else begin
      sum_w = pli_pkg::SUM_W'(ylo_r) + $signed({2'b00, shq_r});
    end
    if (sum_w > pli_pkg::SUM_W'(SAT_MAX)) begin
      sat_w = SAT_MAX;
    end else if (sum_w < pli_pkg::SUM_W'(SAT_MIN)) begin
      sat_w = SAT_MIN;
    end else begin
      sat_w = DW'(sum_w);
    end
  end

  always_comb begin
    sts.few_points = (n_used < pli_pkg::CNT_W'(2));
    sts.below      = (q_r < xlo_r);
    sts.above      = (q_r > rd_x);
    sts.search_end = ((new_hi - new_lo) == IW'(1)) || (new_hi == '0);
    sts.seg_done   = (hi_r == '0) || (dw_w == '0);
    sts.ovf        = (prod_hi >= mdw_r);
    sts.div_last   = (cnt_r == pli_pkg::DCNT_W'(1));
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pli_pkg::OP_ACCEPT: begin
        q_r <= x_value;
      end
      pli_pkg::OP_CAP_LO: begin
        xlo_r  <= rd_x;
        ylo_r  <= rd_y;
        lo_r   <= '0;
        hi_r   <= last_idx;
        // preset for a table too small; overwritten on every other path
        res_r  <= '0;
        stat_r <= pli_pkg::STAT_SMALL;
      end
      pli_pkg::OP_CHECK: begin
        xhi_r <= rd_x;
        yhi_r <= rd_y;
        if (sts.below) begin
          res_r  <= ylo_r;
          stat_r <= pli_pkg::STAT_BELOW;
        end else begin
          res_r  <= rd_y;
          stat_r <= pli_pkg::STAT_ABOVE;
        end
      end
      pli_pkg::OP_MID: begin
        mid_r <= mid_w;
      end
      pli_pkg::OP_STEP: begin
        lo_r <= new_lo;
        hi_r <= new_hi;
        if (go_hi) begin
          xhi_r <= rd_x;
          yhi_r <= rd_y;
        end else begin
          xlo_r <= rd_x;
          ylo_r <= rd_y;
        end
      end
      pli_pkg::OP_DIFF: begin
        mdx_r  <= dx_w[DW] ? DW'(-dx_w) : dx_w[DW-1:0];
        mdy_r  <= dy_w[DW] ? DW'(-dy_w) : dy_w[DW-1:0];
        mdw_r  <= dw_w[DW] ? DW'(-dw_w) : dw_w[DW-1:0];
        neg_r  <= dx_w[DW] ^ dy_w[DW] ^ dw_w[DW];
        // search ending at the low end reads as an interpolated first y
        res_r  <= ylo_r;
        stat_r <= (hi_r == '0) ? pli_pkg::STAT_INTERP : pli_pkg::STAT_ZERO_W;
      end
      pli_pkg::OP_MUL: begin
        prod_r <= pli_pkg::PROD_W'(mdx_r) * pli_pkg::PROD_W'(mdy_r);
      end
      pli_pkg::OP_OVF: begin
        rem_r  <= prod_hi;
        shq_r  <= prod_r[pli_pkg::QUOT_W-1:0];
        cnt_r  <= pli_pkg::DCNT_W'(pli_pkg::DIV_STEPS);
        res_r  <= neg_r ? SAT_MIN : SAT_MAX;
        stat_r <= pli_pkg::STAT_INTERP;
      end
      pli_pkg::OP_DIV: begin
        rem_r <= trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
        shq_r <= {shq_r[pli_pkg::QUOT_W-2:0], trial_ge};
        cnt_r <= cnt_r - pli_pkg::DCNT_W'(1);
      end
      pli_pkg::OP_ADD: begin
        res_r  <= sat_w;
        stat_r <= pli_pkg::STAT_INTERP;
      end
      pli_pkg::OP_OUT: begin
        out_res_r  <= res_r;
        out_stat_r <= stat_r;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/pli_ctrl.sv =====
// ----------------------------------------------------------------------------
// pli_ctrl: controller of the piecewise linear interpolator
// Sequences each query through range checks, binary search, multiply and
// divide, and holds the result handshake.
// ----------------------------------------------------------------------------
module pli_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_kind,
  output logic           in_ready,
  output logic           out_valid_r,
  input  logic           out_ready,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  output pli_pkg::cmd_t  cmd,
  input  pli_pkg::sts_t  sts
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_RDN  = 11'b000_0000_0010,
    S_CHK  = 11'b000_0000_0100,
    S_MID  = 11'b000_0000_1000,
    S_STEP = 11'b000_0001_0000,
    S_DIFF = 11'b000_0010_0000,
    S_MUL  = 11'b000_0100_0000,
    S_OVF  = 11'b000_1000_0000,
    S_DIV  = 11'b001_0000_0000,
    S_ADD  = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_nxt;
  logic   in_fire;
  logic   out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = pli_pkg::OP_NONE;
    cmd.rd_sel = pli_pkg::RD_ZERO;
    cmd.ram_we = in_fire && (in_kind == pli_pkg::KIND_LOAD);
    cmd.cfg_we = cfg_valid;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op = pli_pkg::OP_ACCEPT;
          if (in_kind == pli_pkg::KIND_QUERY) begin
            state_nxt = S_RDN;
          end
        end
      end
      S_RDN: begin
        cmd.op     = pli_pkg::OP_CAP_LO;
        cmd.rd_sel = pli_pkg::RD_LAST;
        state_nxt  = sts.few_points ? S_OUT : S_CHK;
      end
      S_CHK: begin
        cmd.op    = pli_pkg::OP_CHECK;
        state_nxt = (sts.below || sts.above) ? S_OUT : S_MID;
      end
      S_MID: begin
        cmd.op     = pli_pkg::OP_MID;
        cmd.rd_sel = pli_pkg::RD_MID;
        state_nxt  = S_STEP;
      end
      S_STEP: begin
        cmd.op    = pli_pkg::OP_STEP;
        state_nxt = sts.search_end ? S_DIFF : S_MID;
      end
      S_DIFF: begin
        cmd.op    = pli_pkg::OP_DIFF;
        state_nxt = sts.seg_done ? S_OUT : S_MUL;
      end
      S_MUL: begin
        cmd.op    = pli_pkg::OP_MUL;
        state_nxt = S_OVF;
      end
      S_OVF: begin
        cmd.op    = pli_pkg::OP_OVF;
        state_nxt = sts.ovf ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd.op    = pli_pkg::OP_DIV;
        state_nxt = sts.div_last ? S_ADD : S_DIV;
      end
      S_ADD: begin
        cmd.op    = pli_pkg::OP_ADD;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_load) begin
          cmd.op    = pli_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
